[src/mur3_pkg.sv]
// ---------------------------------------------------------------------------
// mur3_pkg
// Shared constants, command codes and control types for the hash engine.
// ---------------------------------------------------------------------------
package mur3_pkg;

  // Mixing constants of the x64_128 variant
  localparam logic [63:0] MUR_C1   = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MUR_C2   = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] MUR_F1   = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] MUR_F2   = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] MUR_ADD1 = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] MUR_ADD2 = 64'h0000_0000_3849_5ab5;

  localparam logic [31:0] SEED_RESET = 32'hdead_b0d7;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam logic [4:0]  FULL_COUNT  = 5'd16;

  // Register map (index taken from paddr[2])
  localparam logic REG_HASH_SEED = 1'b0;

  // Multiplier operand selects
  localparam logic [1:0] MUL_SCR1  = 2'd0;
  localparam logic [1:0] MUL_SCR2  = 2'd1;
  localparam logic [1:0] MUL_FMIX1 = 2'd2;
  localparam logic [1:0] MUL_FMIX2 = 2'd3;

  // Datapath operations
  localparam logic [2:0] DP_NOP      = 3'd0;
  localparam logic [2:0] DP_MIX1     = 3'd1;
  localparam logic [2:0] DP_MIX2     = 3'd2;
  localparam logic [2:0] DP_FIN_PRE  = 3'd3;
  localparam logic [2:0] DP_FIN_POST = 3'd4;
  localparam logic [2:0] DP_DONE     = 3'd5;

  typedef struct packed {
    logic       load;
    logic [1:0] mul_sel;
    logic [2:0] op;
  } mur3_cmd_t;

  typedef struct packed {
    logic last;
  } mur3_sts_t;

endpackage

[src/mur3_mul64.sv]
// ---------------------------------------------------------------------------
// mur3_mul64
// Two-stage 64x64 multiplier keeping the low 64 product bits. Stage one
// registers three 32x32 partial products, stage two sums them.
// ---------------------------------------------------------------------------
module mur3_mul64 (
  input  logic        clk,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic [63:0] prod
);

  logic [63:0] pp_ll_r;
  logic [31:0] pp_lh_r;
  logic [31:0] pp_hl_r;
  logic [63:0] prod_r;

  logic [63:0] pp_ll_nxt;
  logic [63:0] pp_lh_full;
  logic [63:0] pp_hl_full;
  logic [31:0] cross_sum;
  logic [63:0] prod_nxt;

  assign pp_ll_nxt  = op_a[31:0] * op_b[31:0];
  assign pp_lh_full = op_a[31:0] * op_b[63:32];
  assign pp_hl_full = op_a[63:32] * op_b[31:0];

  // only the low half of the cross terms reaches the low 64 bits
  assign cross_sum = pp_lh_r + pp_hl_r;
  assign prod_nxt  = pp_ll_r + {cross_sum, 32'h0};

  always_ff @(posedge clk) begin
    pp_ll_r <= pp_ll_nxt;
    pp_lh_r <= pp_lh_full[31:0];
    pp_hl_r <= pp_hl_full[31:0];
    prod_r  <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

[src/mur3_datapath.sv]
// ---------------------------------------------------------------------------
// mur3_datapath
// Lane states, byte length, block masking, the two lane multipliers and the
// result register.
// ---------------------------------------------------------------------------
module mur3_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mur3_pkg::mur3_cmd_t  cmd,
  output mur3_pkg::mur3_sts_t  sts,
  input  logic [31:0]          seed,
  input  logic [63:0]          in_block_low,
  input  logic [63:0]          in_block_high,
  input  logic [4:0]           in_valid_bytes,
  input  logic                 in_last_block,
  output logic [63:0]          out_hash_value
);
  import mur3_pkg::*;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] xsh33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

  logic [63:0] lane1_r, lane1_nxt;
  logic [63:0] lane2_r, lane2_nxt;
  logic [63:0] k1_r, k1_nxt;
  logic [63:0] k2_r, k2_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] out_r, out_nxt;
  logic        full_r, full_nxt;
  logic        last_r, last_nxt;

  logic [4:0]   cnt_eff;
  logic [127:0] blk_mask;
  logic [63:0]  m1_a, m1_b, m2_a, m2_b;
  logic [63:0]  p1, p2;
  logic [63:0]  mix, lx1, lx2, fa;

  // effective byte count: 16 for a body block, saturated count otherwise
  always_comb begin
    if (!in_last_block || in_valid_bytes > FULL_COUNT) begin
      cnt_eff = FULL_COUNT;
    end else begin
      cnt_eff = in_valid_bytes;
    end
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      blk_mask[8*i +: 8] = {8{(5'(i) < cnt_eff)}};
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SCR1: begin
        m1_a = k1_r;
        m1_b = MUR_C1;
        m2_a = k2_r;
        m2_b = MUR_C2;
      end
      MUL_SCR2: begin
        m1_a = rotl64(p1, 31);
        m1_b = MUR_C2;
        m2_a = rotl64(p2, 33);
        m2_b = MUR_C1;
      end
      MUL_FMIX1: begin
        m1_a = xsh33(lane1_r);
        m1_b = MUR_F1;
        m2_a = xsh33(lane2_r);
        m2_b = MUR_F1;
      end
      MUL_FMIX2: begin
        m1_a = xsh33(p1);
        m1_b = MUR_F2;
        m2_a = xsh33(p2);
        m2_b = MUR_F2;
      end
    endcase
  end

  mur3_mul64 u_mul_one (
    .clk  (clk),
    .op_a (m1_a),
    .op_b (m1_b),
    .prod (p1)
  );

  mur3_mul64 u_mul_two (
    .clk  (clk),
    .op_a (m2_a),
    .op_b (m2_b),
    .prod (p2)
  );

  always_comb begin
    lane1_nxt = lane1_r;
    lane2_nxt = lane2_r;
    k1_nxt    = k1_r;
    k2_nxt    = k2_r;
    len_nxt   = len_r;
    out_nxt   = out_r;
    full_nxt  = full_r;
    last_nxt  = last_r;
    mix       = '0;
    lx1       = lane1_r ^ len_r;
    lx2       = lane2_r ^ len_r;
    fa        = lx1 + lx2;

    if (cmd.load) begin
      k1_nxt   = in_block_low & blk_mask[63:0];
      k2_nxt   = in_block_high & blk_mask[127:64];
      full_nxt = (cnt_eff == FULL_COUNT);
      last_nxt = in_last_block;
      len_nxt  = len_r + 64'(cnt_eff);
      // zero length marks a message start: lanes restart from the seed
      if (len_r == 64'd0) begin
        lane1_nxt = {32'h0, seed};
        lane2_nxt = {32'h0, seed};
      end
    end

    unique case (cmd.op)
      DP_MIX1: begin
        if (full_r) begin
          mix       = rotl64(lane1_r ^ p1, 27) + lane2_r;
          lane1_nxt = (mix << 2) + mix + MUR_ADD1;
          k2_nxt    = p2;
        end else begin
          lane1_nxt = lane1_r ^ p1;
          lane2_nxt = lane2_r ^ p2;
        end
      end
      DP_MIX2: begin
        if (full_r) begin
          mix       = rotl64(lane2_r ^ k2_r, 31) + lane1_r;
          lane2_nxt = (mix << 2) + mix + MUR_ADD2;
        end
      end
      DP_FIN_PRE: begin
        lane1_nxt = fa;
        lane2_nxt = lx2 + fa;
      end
      DP_FIN_POST: begin
        lane1_nxt = xsh33(p1);
        lane2_nxt = xsh33(p2);
      end
      DP_DONE: begin
        // a += b; b += a  ->  b_final = a + 2b
        out_nxt = lane1_r + (lane2_r << 1);
        len_nxt = 64'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 64'd0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lane1_r <= lane1_nxt;
    lane2_r <= lane2_nxt;
    k1_r    <= k1_nxt;
    k2_r    <= k2_nxt;
    out_r   <= out_nxt;
    full_r  <= full_nxt;
    last_r  <= last_nxt;
  end

  assign sts.last       = last_r;
  assign out_hash_value = out_r;

endmodule

[src/mur3_ctrl.sv]
// ---------------------------------------------------------------------------
// mur3_ctrl
// Sequencer for one block: scramble multiplies, lane mix, and on the last
// block the finalizer and result handoff.
// ---------------------------------------------------------------------------
module mur3_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mur3_pkg::mur3_cmd_t  cmd,
  input  mur3_pkg::mur3_sts_t  sts
);
  import mur3_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1A  = 4'd1;
  localparam logic [3:0] S_M1B  = 4'd2;
  localparam logic [3:0] S_M2A  = 4'd3;
  localparam logic [3:0] S_M2B  = 4'd4;
  localparam logic [3:0] S_MIX1 = 4'd5;
  localparam logic [3:0] S_MIX2 = 4'd6;
  localparam logic [3:0] S_FIN0 = 4'd7;
  localparam logic [3:0] S_F1A  = 4'd8;
  localparam logic [3:0] S_F1B  = 4'd9;
  localparam logic [3:0] S_F2A  = 4'd10;
  localparam logic [3:0] S_F2B  = 4'd11;
  localparam logic [3:0] S_FIN3 = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  // result slot is free if empty or drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.load      = accept;
    cmd.mul_sel   = MUL_SCR1;
    cmd.op        = DP_NOP;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_M1A;
        end
      end
      S_M1A:  state_nxt = S_M1B;
      S_M1B:  state_nxt = S_M2A;
      S_M2A: begin
        cmd.mul_sel = MUL_SCR2;
        state_nxt   = S_M2B;
      end
      S_M2B:  state_nxt = S_MIX1;
      S_MIX1: begin
        cmd.op    = DP_MIX1;
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        cmd.op    = DP_MIX2;
        state_nxt = sts.last ? S_FIN0 : S_IDLE;
      end
      S_FIN0: begin
        cmd.op    = DP_FIN_PRE;
        state_nxt = S_F1A;
      end
      S_F1A: begin
        cmd.mul_sel = MUL_FMIX1;
        state_nxt   = S_F1B;
      end
      S_F1B:  state_nxt = S_F2A;
      S_F2A: begin
        cmd.mul_sel = MUL_FMIX2;
        state_nxt   = S_F2B;
      end
      S_F2B:  state_nxt = S_FIN3;
      S_FIN3: begin
        cmd.op    = DP_FIN_POST;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op        = DP_DONE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a result only appears from the handoff state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside handoff");

  // handoff waits while the previous result is still stalled
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("handoff overran a held result");

  // a body block goes straight back to idle without finalizing
  a_body_no_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX2 && !sts.last) |=> (state_r == S_IDLE))
    else $error("body block entered finalizer");

  // new input only enters when the block is back in idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_M1A))
    else $error("load did not start a block");

endmodule

[src/murmur3_x64_hash_engine.sv]
// A new block is taken only in idle, after the sequencer is through with the
// one before; a last block also holds input through the finalizer and the
// handoff, which a held result blocks. Each 64-bit multiply runs in the
// pipelined mur3_mul64; the block and finalizer chains need two each.
// Reset (rst_n low, synchronous) clears the sequencer, the result flag and
// the byte length, and loads the seed register with 0xdeadb0d7.
// ---------------------------------------------------------------------------
// murmur3_x64_hash_engine
// Streaming MurmurHash3 x64_128 engine over 16-byte blocks; outputs the
// second 64-bit half of the digest. Seed set through an APB-style port.
// ---------------------------------------------------------------------------
module murmur3_x64_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  input  logic [4:0]  in_valid_bytes,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);
  import mur3_pkg::*;

  logic [31:0] seed_r, seed_nxt;
  logic        seed_wr;
  mur3_cmd_t   cmd;
  mur3_sts_t   sts;

  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && (paddr[2] == REG_HASH_SEED);
  assign seed_nxt = seed_wr ? pwdata : seed_r;
  assign prdata  = (paddr[2] == REG_HASH_SEED) ? seed_r : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  mur3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mur3_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .seed           (seed_r),
    .in_block_low   (in_block_low),
    .in_block_high  (in_block_high),
    .in_valid_bytes (in_valid_bytes),
    .in_last_block  (in_last_block),
    .out_hash_value (out_hash_value)
  );

endmodule
